@@ hw/rtl/wsfr_pkg.sv @@
package wsfr_pkg;

   // Result kinds
   localparam logic [2:0] KIND_TEXT    = 3'd0;
   localparam logic [2:0] KIND_END     = 3'd1;
   localparam logic [2:0] KIND_PONG    = 3'd2;
   localparam logic [2:0] KIND_ABANDON = 3'd3;
   localparam logic [2:0] KIND_CLOSED  = 3'd4;
   localparam logic [2:0] KIND_ERROR   = 3'd5;

   // Error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_LEN64     = 2'd1;
   localparam logic [1:0] ERR_FRAME_LEN = 2'd2;
   localparam logic [1:0] ERR_MSG_LEN   = 2'd3;

   // Frame opcodes
   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;

   // Header constants
   localparam logic [6:0]  LEN_EXT16      = 7'd126;
   localparam logic [6:0]  LEN_EXT64      = 7'd127;
   localparam logic [15:0] PING_MAX_LEN   = 16'd125;
   localparam logic [2:0]  MASK_KEY_BYTES = 3'd4;
   localparam logic [7:0]  PONG_FIRST     = 8'h8A;
   localparam logic [2:0]  PONG_HDR_LAST  = 3'd5;

   // Configuration register indexes
   localparam logic CSR_MAX_FRAME_LEN  = 1'b0;
   localparam logic CSR_DELIVERY_LIMIT = 1'b1;

   localparam logic [16:0] MAX_FRAME_LEN_RESET  = 17'h10000;
   localparam logic [16:0] DELIVERY_LIMIT_RESET = 17'h10000;

   // Command queue between parser and result sequencer
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // At most one command per parsed byte; the flags are emitted in declaration order
   typedef struct packed {
      logic       abandon;
      logic       error;
      logic [1:0] err_code;
      logic       pong_hdr;
      logic [6:0] pong_len;
      logic       text;
      logic       pong_byte;
      logic [7:0] data;
      logic       last;
      logic       text_end;
      logic       closed;
   } wsfr_cmd_type;

   function automatic logic cmd_any(input wsfr_cmd_type c);
      return c.abandon | c.error | c.pong_hdr | c.text | c.pong_byte | c.text_end | c.closed;
   endfunction

endpackage

@@ hw/rtl/wsfr_front.sv @@
module wsfr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_accept,
   input  logic [7:0]            rx_byte,
   input  logic [16:0]           max_frame_len,
   input  logic [16:0]           delivery_limit,
   output logic                  cmd_push,
   output wsfr_pkg::wsfr_cmd_type cmd
);
   import wsfr_pkg::*;

   typedef enum logic [5:0] {
      PH_FIRST   = 6'b000001,
      PH_SECOND  = 6'b000010,
      PH_EXT_HI  = 6'b000100,
      PH_EXT_LO  = 6'b001000,
      PH_MASK    = 6'b010000,
      PH_PAYLOAD = 6'b100000
   } wsfr_phase_type;

   wsfr_phase_type phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_present_ff, mask_present_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [2:0]  mask_skip_ff, mask_skip_in;
   logic        assembling_ff, assembling_in;
   logic [16:0] assembled_count_ff, assembled_count_in;
   logic        halted_ff, halted_in;
   logic        pong_active_ff, pong_active_in;

   wsfr_cmd_type c;
   logic        is_data_op;
   logic        do_lk, do_hd, do_fd;
   logic [16:0] lk_len;
   logic [15:0] hd_len;
   logic        ab;
   logic [16:0] cnt;
   logic [17:0] sum;

   assign is_data_op = (opcode_ff == OP_CONT) || (opcode_ff == OP_TEXT);

   always_comb begin
      phase_in           = phase_ff;
      fin_in             = fin_ff;
      opcode_in          = opcode_ff;
      mask_present_in    = mask_present_ff;
      length_high_in     = length_high_ff;
      bytes_left_in      = bytes_left_ff;
      mask_skip_in       = mask_skip_ff;
      assembling_in      = assembling_ff;
      assembled_count_in = assembled_count_ff;
      halted_in          = halted_ff;
      pong_active_in     = pong_active_ff;
      c      = '0;
      do_lk  = 1'b0;
      do_hd  = 1'b0;
      do_fd  = 1'b0;
      lk_len = '0;
      hd_len = '0;
      ab     = assembling_ff;
      cnt    = assembled_count_ff;
      sum    = '0;

      if (byte_accept && !halted_ff) begin
         case (phase_ff)
            PH_FIRST: begin
               fin_in    = rx_byte[7];
               opcode_in = rx_byte[3:0];
               phase_in  = PH_SECOND;
            end
            PH_SECOND: begin
               mask_present_in = rx_byte[7];
               if (rx_byte[6:0] == LEN_EXT16) begin
                  phase_in = PH_EXT_HI;
               end else if (rx_byte[6:0] == LEN_EXT64) begin
                  c.error    = 1'b1;
                  c.err_code = ERR_LEN64;
                  halted_in  = 1'b1;
               end else begin
                  do_lk  = 1'b1;
                  lk_len = {10'd0, rx_byte[6:0]};
               end
            end
            PH_EXT_HI: begin
               length_high_in = rx_byte;
               phase_in       = PH_EXT_LO;
            end
            PH_EXT_LO: begin
               do_lk  = 1'b1;
               lk_len = {1'b0, length_high_ff, rx_byte};
            end
            PH_MASK: begin
               mask_skip_in = mask_skip_ff - 3'd1;
               if (mask_skip_ff == 3'd1) begin
                  do_hd  = 1'b1;
                  hd_len = bytes_left_ff;
               end
            end
            PH_PAYLOAD: begin
               if (is_data_op && assembling_ff) begin
                  if (({1'b0, assembled_count_ff} + 18'd1) < {1'b0, delivery_limit}) begin
                     c.text = 1'b1;
                     c.data = rx_byte;
                  end
                  assembled_count_in = assembled_count_ff + 17'd1;
               end else if (opcode_ff == OP_PING && pong_active_ff) begin
                  c.pong_byte = 1'b1;
                  c.data      = rx_byte;
                  c.last      = (bytes_left_ff == 16'd1);
               end
               bytes_left_in = bytes_left_ff - 16'd1;
               if (bytes_left_ff == 16'd1) do_fd = 1'b1;
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase

         // Length known: check frame limit, then skip mask key or finish header
         if (do_lk) begin
            if (lk_len > max_frame_len) begin
               c.error    = 1'b1;
               c.err_code = ERR_FRAME_LEN;
               halted_in  = 1'b1;
            end else begin
               bytes_left_in = lk_len[15:0];
               if (mask_present_in) begin
                  mask_skip_in = MASK_KEY_BYTES;
                  phase_in     = PH_MASK;
               end else begin
                  do_hd  = 1'b1;
                  hd_len = lk_len[15:0];
               end
            end
         end

         // Header complete
         if (do_hd) begin
            if (opcode_ff == OP_TEXT) begin
               c.abandon = assembling_ff;
               cnt       = '0;
               ab        = 1'b1;
            end
            sum = {1'b0, cnt} + {2'b0, hd_len};
            assembling_in      = ab;
            assembled_count_in = cnt;
            if (is_data_op && ab && (sum > {1'b0, max_frame_len})) begin
               c.error    = 1'b1;
               c.err_code = ERR_MSG_LEN;
               halted_in  = 1'b1;
            end else begin
               pong_active_in = (opcode_ff == OP_PING) && (hd_len <= PING_MAX_LEN);
               if (pong_active_in) begin
                  c.pong_hdr = 1'b1;
                  c.pong_len = hd_len[6:0];
               end
               if (hd_len == 16'd0) do_fd = 1'b1;
               else phase_in = PH_PAYLOAD;
            end
         end

         // Frame complete
         if (do_fd) begin
            phase_in       = PH_FIRST;
            pong_active_in = 1'b0;
            if (opcode_ff == OP_CLOSE) begin
               c.closed  = 1'b1;
               halted_in = 1'b1;
            end else if (is_data_op && assembling_in && fin_ff) begin
               c.text_end         = 1'b1;
               assembling_in      = 1'b0;
               assembled_count_in = '0;
            end
         end
      end
   end

   assign cmd      = c;
   assign cmd_push = cmd_any(c);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_FIRST;
         fin_ff             <= 1'b0;
         opcode_ff          <= '0;
         mask_present_ff    <= 1'b0;
         length_high_ff     <= '0;
         bytes_left_ff      <= '0;
         mask_skip_ff       <= '0;
         assembling_ff      <= 1'b0;
         assembled_count_ff <= '0;
         halted_ff          <= 1'b0;
         pong_active_ff     <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         fin_ff             <= fin_in;
         opcode_ff          <= opcode_in;
         mask_present_ff    <= mask_present_in;
         length_high_ff     <= length_high_in;
         bytes_left_ff      <= bytes_left_in;
         mask_skip_ff       <= mask_skip_in;
         assembling_ff      <= assembling_in;
         assembled_count_ff <= assembled_count_in;
         halted_ff          <= halted_in;
         pong_active_ff     <= pong_active_in;
      end
   end

endmodule

@@ hw/rtl/wsfr_cmd_queue.sv @@
module wsfr_cmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wsfr_pkg::wsfr_cmd_type push_data,
   output logic                   full,
   input  logic                   pop,
   output wsfr_pkg::wsfr_cmd_type pop_data,
   output logic                   empty
);
   import wsfr_pkg::*;

   wsfr_cmd_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/wsfr_back.sv @@
module wsfr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  wsfr_pkg::wsfr_cmd_type q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_kind,
   output logic [7:0]             rsp_data,
   output logic                   rsp_pong_last,
   output logic [1:0]             rsp_error_code
);
   import wsfr_pkg::*;

   wsfr_cmd_type cur_ff, cur_in, nxt;
   logic         cur_valid_ff, cur_valid_in;
   logic [2:0]   idx_ff, idx_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [2:0]   kind_ff, kind_in;
   logic [7:0]   data_ff, data_in;
   logic         last_ff, last_in;
   logic [1:0]   err_ff, err_in;

   logic         out_free, emit, load;
   logic [2:0]   e_kind;
   logic [7:0]   e_data;
   logic         e_last;
   logic [1:0]   e_err;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      nxt    = cur_ff;
      idx_in = idx_ff;
      emit   = 1'b0;
      e_kind = KIND_TEXT;
      e_data = '0;
      e_last = 1'b0;
      e_err  = ERR_NONE;

      // Emit the first pending item of the current command
      if (cur_valid_ff && out_free) begin
         emit = 1'b1;
         if (cur_ff.abandon) begin
            e_kind      = KIND_ABANDON;
            nxt.abandon = 1'b0;
         end else if (cur_ff.error) begin
            e_kind    = KIND_ERROR;
            e_err     = cur_ff.err_code;
            nxt.error = 1'b0;
         end else if (cur_ff.pong_hdr) begin
            e_kind = KIND_PONG;
            case (idx_ff)
               3'd0:    e_data = PONG_FIRST;
               3'd1:    e_data = {1'b1, cur_ff.pong_len};
               default: e_data = '0;
            endcase
            if (idx_ff == PONG_HDR_LAST) begin
               e_last       = (cur_ff.pong_len == '0);
               nxt.pong_hdr = 1'b0;
               idx_in       = '0;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end else if (cur_ff.text) begin
            e_kind   = KIND_TEXT;
            e_data   = cur_ff.data;
            nxt.text = 1'b0;
         end else if (cur_ff.pong_byte) begin
            e_kind        = KIND_PONG;
            e_data        = cur_ff.data;
            e_last        = cur_ff.last;
            nxt.pong_byte = 1'b0;
         end else if (cur_ff.text_end) begin
            e_kind       = KIND_END;
            nxt.text_end = 1'b0;
         end else begin
            e_kind     = KIND_CLOSED;
            nxt.closed = 1'b0;
         end
      end

      // Take the next command once the current one is drained
      load  = !cur_valid_ff || (emit && !cmd_any(nxt));
      q_pop = load && !q_empty;
      if (load) begin
         cur_valid_in = !q_empty;
         cur_in       = q_data;
         idx_in       = '0;
      end else begin
         cur_valid_in = 1'b1;
         cur_in       = nxt;
      end

      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         kind_in      = e_kind;
         data_in      = e_data;
         last_in      = e_last;
         err_in       = e_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      kind_ff <= kind_in;
      data_ff <= data_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_data       = data_ff;
   assign rsp_pong_last  = last_ff;
   assign rsp_error_code = err_ff;

endmodule

@@ hw/rtl/websocket_frame_receiver_core.sv @@
// WebSocket frame receiver: parses server-to-client frames one byte at a time.
// req_* carries received bytes (req_valid / req_stall). rsp_* carries results:
// text bytes, text end, pong bytes (pong frame with zero mask key), abandoned
// message, closed, and error with a code. csr_* writes max_frame_len (index 0)
// and delivery_limit (index 1); write only while no transaction is in flight.
// Throughput: one byte per cycle while req_stall is low. The parser turns each
// byte into at most one command that goes through a four-entry queue; the result
// sequencer emits one result per cycle while rsp_stall is low, so a ping header
// (six pong bytes) or a byte with several results holds the output until all are
// out, and the queue absorbs the burst. A byte's results pass through the queue,
// the current-command and output registers. req_stall rises only when the command
// queue is full, which follows from rsp_stall held high or from result bursts.
// Reset clears the parser to await a frame header, empties the queue and sets
// both registers to 65536. After a close frame or an error, every further byte
// is taken and ignored until reset.
module websocket_frame_receiver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic        rsp_pong_last,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);
   import wsfr_pkg::*;

   logic [16:0]  max_frame_len_ff;
   logic [16:0]  delivery_limit_ff;
   logic         byte_accept;
   logic         cmd_push;
   wsfr_cmd_type cmd;
   logic         q_full, q_empty, q_pop;
   wsfr_cmd_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_len_ff  <= MAX_FRAME_LEN_RESET;
         delivery_limit_ff <= DELIVERY_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_FRAME_LEN:  max_frame_len_ff  <= csr_wdata;
            CSR_DELIVERY_LIMIT: delivery_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall   = q_full;
   assign byte_accept = req_valid && !req_stall;

   wsfr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .byte_accept    (byte_accept),
      .rx_byte        (req_rx_byte),
      .max_frame_len  (max_frame_len_ff),
      .delivery_limit (delivery_limit_ff),
      .cmd_push       (cmd_push),
      .cmd            (cmd)
   );

   wsfr_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   wsfr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_data       (rsp_data),
      .rsp_pong_last  (rsp_pong_last),
      .rsp_error_code (rsp_error_code)
   );

endmodule
